// File: rtl/core/tms_pkg.sv
package tms_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int DIV_W       = 15;
    localparam int STRIDE_W    = 15;
    localparam int XOFF_W      = 14;

    localparam logic [2:0] FMT_RGBA = 3'd0;
    localparam logic [2:0] FMT_CI   = 3'd2;
    localparam logic [2:0] FMT_IA   = 3'd3;
    localparam logic [2:0] FMT_I    = 3'd4;

    localparam logic [1:0] PAL_NONE   = 2'd0;
    localparam logic [1:0] PAL_RGBA16 = 2'd1;
    localparam logic [1:0] PAL_IA16   = 2'd2;

    localparam logic [2:0] REG_FORMAT  = 3'd0;
    localparam logic [2:0] REG_SIZE    = 3'd1;
    localparam logic [2:0] REG_BASE    = 3'd2;
    localparam logic [2:0] REG_LINE    = 3'd3;
    localparam logic [2:0] REG_WIDTH   = 3'd4;
    localparam logic [2:0] REG_PALMODE = 3'd5;
    localparam logic [2:0] REG_PALSEL  = 3'd6;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV,
        ST_READ,
        ST_CAP,
        ST_PAL_HI,
        ST_PAL_LO,
        ST_PAL_CAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [31:0] from5551(input logic [15:0] v);
        return {v[15:11], v[15:13], v[10:6], v[10:8], v[5:1], v[5:3], {8{v[0]}}};
    endfunction

    function automatic logic [31:0] from88(input logic [15:0] v);
        return {v[15:8], v[15:8], v[15:8], v[7:0]};
    endfunction

endpackage

// File: rtl/core/tms_div.sv
module tms_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tms_pkg::div_req_t  req,
    output tms_pkg::div_rsp_t  rsp
);

    logic [tms_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [tms_pkg::DIV_W-1:0] dvd_reg, dvd_next;
    logic [tms_pkg::DIV_W-1:0] dsr_reg, dsr_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [tms_pkg::DIV_W:0]   trial;

    // One restoring step per cycle: shift in a dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[tms_pkg::DIV_W-1]};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = 4'(tms_pkg::DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = tms_pkg::DIV_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = tms_pkg::DIV_W'(trial);
            end
            dvd_next = {dvd_reg[tms_pkg::DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg) else $error("divider did not start");
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < dsr_reg) else $error("remainder not reduced");

endmodule

// File: rtl/core/texture_memory_texel_sampler.sv
// Texel sampler over a 4096-byte texture memory. A write transfer stores one
// byte and yields nothing; a sample transfer yields one RGBA8888 texel decoded
// per the format, size and palette registers. After reset the block clears
// the memory, one byte per cycle, with in_stall high. A write is taken in the
// idle state and leaves the block idle. A sample holds in_stall high until its
// texel is loaded into the output register: every texel byte fetch runs the
// single 15-step serial divider to find the offset within the row for the
// odd-row word swap, then reads the memory. A finished texel sits in the
// output register while the next transfer is taken; a sample that finishes
// while it is still full waits.
module texture_memory_texel_sampler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [11:0] write_address,
    input  logic [7:0]  write_data,
    input  logic [11:0] texel_x,
    input  logic [11:0] texel_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha
);

    localparam int AW = tms_pkg::ADDR_W;

    tms_pkg::state_t state_reg, state_next;

    logic [2:0]  fmt_reg;
    logic [1:0]  size_reg;
    logic [8:0]  base_reg;
    logic [8:0]  line_reg;
    logic [12:0] width_reg;
    logic [1:0]  palm_reg;
    logic [3:0]  pals_reg;

    logic [7:0]  mem [tms_pkg::STORE_BYTES];
    logic [7:0]  rdata_reg;
    logic [AW-1:0] clr_reg;
    logic [1:0]  fk_reg;

    logic [11:0] x_reg, y_reg;
    logic [tms_pkg::STRIDE_W-1:0] stride_reg;
    logic [tms_pkg::XOFF_W-1:0]   xoff_reg;
    logic [AW-1:0] ystride_reg;
    logic [7:0]  p0_reg, p1_reg, p2_reg, p3_reg;
    logic        out_valid_reg;
    logic [31:0] pix_reg;

    logic        rgba32, pal;
    logic [1:0]  shift;
    logic [15:0] row_bytes;
    logic [tms_pkg::STRIDE_W-1:0] stride_calc;
    logic [14:0] xoff_calc;
    logic [26:0] yprod;
    logic        accept, take_out;
    logic        mem_we;
    logic [AW-1:0] mem_wa, rd_addr;
    logic [7:0]  mem_wd;
    logic [1:0]  dk;
    logic [tms_pkg::DIV_W-1:0] dvd;
    logic [AW-1:0] rel, rem12, fa, fetch_addr, pa;
    logic [3:0]  nib;
    logic [31:0] pix;
    logic [7:0]  ia4;
    logic        div_go, cap, load_out;

    tms_pkg::div_req_t div_req;
    tms_pkg::div_rsp_t div_rsp;

    assign rgba32   = (fmt_reg == tms_pkg::FMT_RGBA) && (size_reg == 2'd3);
    assign pal      = (palm_reg != tms_pkg::PAL_NONE);
    assign shift    = rgba32 ? 2'd2 : size_reg;
    assign accept   = in_valid && !in_stall;
    assign take_out = out_valid_reg && !out_stall;

    // Stride is the larger of the pitch and the row size, at least one byte
    always_comb
    begin
        row_bytes = 16'(({3'b000, width_reg} << shift) >> 1);
        if (row_bytes == 16'd0)
        begin
            row_bytes = 16'd1;
        end
        if (row_bytes > {4'd0, line_reg, 3'b000})
        begin
            stride_calc = tms_pkg::STRIDE_W'(row_bytes);
        end
        else
        begin
            stride_calc = tms_pkg::STRIDE_W'({line_reg, 3'b000});
        end
        xoff_calc = 15'(({3'b000, texel_x} << shift) >> 1);
    end

    assign yprod = 27'(y_reg) * 27'(stride_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tms_pkg::ST_CLEAR:
            begin
                if (&clr_reg)
                begin
                    state_next = tms_pkg::ST_IDLE;
                end
            end
            tms_pkg::ST_IDLE:
            begin
                if (accept && func)
                begin
                    state_next = tms_pkg::ST_MUL;
                end
            end
            tms_pkg::ST_MUL:    state_next = tms_pkg::ST_DIV_GO;
            tms_pkg::ST_DIV_GO: state_next = tms_pkg::ST_DIV;
            tms_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = tms_pkg::ST_READ;
                end
            end
            tms_pkg::ST_READ:   state_next = tms_pkg::ST_CAP;
            tms_pkg::ST_CAP:
            begin
                if (pal && fk_reg == 2'd1)
                begin
                    state_next = tms_pkg::ST_PAL_HI;
                end
                else if (fk_reg == 2'd3)
                begin
                    state_next = tms_pkg::ST_DONE;
                end
                else
                begin
                    state_next = tms_pkg::ST_DIV_GO;
                end
            end
            tms_pkg::ST_PAL_HI:  state_next = tms_pkg::ST_PAL_LO;
            tms_pkg::ST_PAL_LO:  state_next = tms_pkg::ST_PAL_CAP;
            tms_pkg::ST_PAL_CAP: state_next = tms_pkg::ST_DONE;
            tms_pkg::ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    state_next = tms_pkg::ST_IDLE;
                end
            end
            default: state_next = tms_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_stall = 1'b1;
        div_go   = 1'b0;
        cap      = 1'b0;
        load_out = 1'b0;
        rd_addr  = '0;
        unique case (state_reg)
            tms_pkg::ST_IDLE:   in_stall = 1'b0;
            tms_pkg::ST_DIV_GO: div_go = 1'b1;
            tms_pkg::ST_READ:   rd_addr = fetch_addr;
            tms_pkg::ST_CAP:    cap = 1'b1;
            tms_pkg::ST_PAL_HI: rd_addr = pa;
            tms_pkg::ST_PAL_LO: rd_addr = AW'(pa + AW'(1));
            tms_pkg::ST_DONE:   load_out = !out_valid_reg;
            default:            in_stall = 1'b1;
        endcase
    end

    // Offset of this fetch from the texel's first byte
    always_comb
    begin
        case (fk_reg)
            2'd0:    dk = 2'd0;
            2'd1:    dk = 2'd1;
            2'd2:    dk = rgba32 ? 2'd0 : 2'd2;
            default: dk = rgba32 ? 2'd1 : 2'd3;
        endcase
        dvd = tms_pkg::DIV_W'(xoff_reg) + tms_pkg::DIV_W'(dk);
    end

    assign div_req.start    = div_go;
    assign div_req.dividend = dvd;
    assign div_req.divisor  = stride_reg;

    tms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Fetch address: swap 32-bit words within the row on odd rows, then mask
    always_comb
    begin
        rel   = AW'(ystride_reg + dvd[AW-1:0]);
        rem12 = div_rsp.rem[AW-1:0];
        if (y_reg[0])
        begin
            fa = AW'({base_reg, 3'b000} + rel - rem12
                     + ((rem12 & ~AW'(3)) ^ AW'(4)) + AW'(rel[1:0]));
        end
        else
        begin
            fa = AW'({base_reg, 3'b000} + rel);
        end
        fetch_addr = fa;
        if (rgba32 || pal)
        begin
            fetch_addr[AW-1] = rgba32 && fk_reg[1];
        end
    end

    assign nib = x_reg[0] ? p0_reg[3:0] : p0_reg[7:4];

    always_comb
    begin
        if (size_reg == 2'd0)
        begin
            pa = AW'(12'h800 + {1'b0, pals_reg, 7'd0} + {5'd0, nib, 3'd0});
        end
        else
        begin
            pa = AW'(12'h800 + {1'b0, p0_reg, 3'd0});
        end
    end

    // Decode the gathered bytes into RGBA
    always_comb
    begin
        pix = 32'h0000_00FF;
        ia4 = {nib[3:1], nib[3:1], nib[3:2]};
        if (pal)
        begin
            case (palm_reg)
                tms_pkg::PAL_RGBA16: pix = tms_pkg::from5551({p2_reg, p3_reg});
                tms_pkg::PAL_IA16:   pix = tms_pkg::from88({p2_reg, p3_reg});
                default:             pix = 32'h0000_00FF;
            endcase
        end
        else
        begin
            case (size_reg)
                2'd0:
                begin
                    if (fmt_reg == tms_pkg::FMT_IA)
                    begin
                        pix = {ia4, ia4, ia4, {8{nib[0]}}};
                    end
                    else if (fmt_reg == tms_pkg::FMT_I || fmt_reg == tms_pkg::FMT_RGBA
                             || fmt_reg == tms_pkg::FMT_CI)
                    begin
                        pix = {nib, nib, nib, nib, nib, nib, 8'hFF};
                    end
                end
                2'd1:
                begin
                    if (fmt_reg == tms_pkg::FMT_IA)
                    begin
                        pix = {p0_reg[7:4], p0_reg[7:4], p0_reg[7:4], p0_reg[7:4],
                               p0_reg[7:4], p0_reg[7:4], p0_reg[3:0], p0_reg[3:0]};
                    end
                    else if (fmt_reg == tms_pkg::FMT_I || fmt_reg == tms_pkg::FMT_RGBA
                             || fmt_reg == tms_pkg::FMT_CI)
                    begin
                        pix = {p0_reg, p0_reg, p0_reg, 8'hFF};
                    end
                end
                2'd2:
                begin
                    if (fmt_reg == tms_pkg::FMT_RGBA)
                    begin
                        pix = tms_pkg::from5551({p0_reg, p1_reg});
                    end
                    else if (fmt_reg == tms_pkg::FMT_IA)
                    begin
                        pix = tms_pkg::from88({p0_reg, p1_reg});
                    end
                    else if (fmt_reg == tms_pkg::FMT_CI || fmt_reg == tms_pkg::FMT_I)
                    begin
                        pix = {p0_reg, p1_reg, p0_reg, p1_reg};
                    end
                end
                default:
                begin
                    if (fmt_reg == tms_pkg::FMT_RGBA)
                    begin
                        pix = {p0_reg, p1_reg, p2_reg, p3_reg};
                    end
                    else if (fmt_reg == tms_pkg::FMT_CI || fmt_reg == tms_pkg::FMT_IA
                             || fmt_reg == tms_pkg::FMT_I)
                    begin
                        pix = x_reg[0] ? {p0_reg, p1_reg, p0_reg, p1_reg}
                                       : {p2_reg, p3_reg, p2_reg, p3_reg};
                    end
                end
            endcase
        end
    end

    // Memory write port: clearing sweep or a write transfer
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = write_address;
        mem_wd = write_data;
        if (state_reg == tms_pkg::ST_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = clr_reg;
            mem_wd = 8'd0;
        end
        else if (accept && !func)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tms_pkg::ST_CLEAR;
            clr_reg       <= '0;
            fk_reg        <= '0;
            out_valid_reg <= 1'b0;
            fmt_reg       <= '0;
            size_reg      <= '0;
            base_reg      <= '0;
            line_reg      <= '0;
            width_reg     <= 13'd1;
            palm_reg      <= '0;
            pals_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tms_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (state_reg == tms_pkg::ST_MUL)
            begin
                fk_reg <= '0;
            end
            else if (cap)
            begin
                fk_reg <= fk_reg + 2'd1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (take_out)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    tms_pkg::REG_FORMAT:  fmt_reg   <= cfg_data[2:0];
                    tms_pkg::REG_SIZE:    size_reg  <= cfg_data[1:0];
                    tms_pkg::REG_BASE:    base_reg  <= cfg_data[8:0];
                    tms_pkg::REG_LINE:    line_reg  <= cfg_data[8:0];
                    tms_pkg::REG_WIDTH:   width_reg <= cfg_data;
                    tms_pkg::REG_PALMODE: palm_reg  <= cfg_data[1:0];
                    tms_pkg::REG_PALSEL:  pals_reg  <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath holds
    always_ff @(posedge clk)
    begin
        if (accept && func)
        begin
            x_reg      <= texel_x;
            y_reg      <= texel_y;
            stride_reg <= stride_calc;
            xoff_reg   <= tms_pkg::XOFF_W'(xoff_calc);
        end
        if (state_reg == tms_pkg::ST_MUL)
        begin
            ystride_reg <= yprod[AW-1:0];
        end
        if (cap)
        begin
            case (fk_reg)
                2'd0:    p0_reg <= rdata_reg;
                2'd1:    p1_reg <= rdata_reg;
                2'd2:    p2_reg <= rdata_reg;
                default: p3_reg <= rdata_reg;
            endcase
        end
        if (state_reg == tms_pkg::ST_PAL_LO)
        begin
            p2_reg <= rdata_reg;
        end
        if (state_reg == tms_pkg::ST_PAL_CAP)
        begin
            p3_reg <= rdata_reg;
        end
        if (load_out)
        begin
            pix_reg <= pix;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = pix_reg[31:24];
    assign green     = pix_reg[23:16];
    assign blue      = pix_reg[15:8];
    assign alpha     = pix_reg[7:0];

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func) |=> in_stall) else $error("sample transfer did not hold input");
    a_div_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == tms_pkg::ST_DIV) else $error("stray divider result");
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tms_pkg::ST_CLEAR |-> !out_valid_reg) else $error("result during clear");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg) else $error("result lost");

endmodule
